### src/ceiling_speed_supervisor_top_macros.svh
// Assertion macros for the ceiling speed supervisor.
// Clock clk_i and active-low reset rst_ni must be in scope at the point of use.
`ifndef CEILING_SPEED_SUPERVISOR_TOP_MACROS_SVH
`define CEILING_SPEED_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication.
`define CSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/css_pkg.sv
// Shared types, constants and result mapping for the ceiling speed supervisor.
// No dependencies.
`timescale 1ns / 1ps

package css_pkg;

  localparam int unsigned SPEED_WIDTH     = 16;
  localparam int unsigned SPEED_FRAC_BITS = 6;
  localparam int unsigned SCALE           = 1 << SPEED_FRAC_BITS;

  // Numerator widths of the three sloped margin segments.
  localparam int unsigned NUM_W_WIDTH = $clog2(150 * SCALE + 16);
  localparam int unsigned NUM_S_WIDTH = $clog2(2000 * SCALE + 101);
  localparam int unsigned NUM_E_WIDTH = $clog2(600 * SCALE + 21);

  localparam int unsigned CALC_WIDTH =
    ((SPEED_WIDTH > NUM_S_WIDTH) ? SPEED_WIDTH : NUM_S_WIDTH) + 2;
  localparam int unsigned MARGIN_WIDTH = $clog2(15 * SCALE + 1);

  localparam logic [CALC_WIDTH-1:0] V110 = CALC_WIDTH'(110 * SCALE);
  localparam logic [CALC_WIDTH-1:0] V140 = CALC_WIDTH'(140 * SCALE);
  localparam logic [CALC_WIDTH-1:0] V210 = CALC_WIDTH'(210 * SCALE);

  localparam logic [MARGIN_WIDTH-1:0] MRG_W_LO = MARGIN_WIDTH'(4 * SCALE);
  localparam logic [MARGIN_WIDTH-1:0] MRG_W_HI = MARGIN_WIDTH'(5 * SCALE);
  localparam logic [MARGIN_WIDTH-1:0] MRG_S_LO = MARGIN_WIDTH'((11 * SCALE) / 2);
  localparam logic [MARGIN_WIDTH-1:0] MRG_S_HI = MARGIN_WIDTH'(10 * SCALE);
  localparam logic [MARGIN_WIDTH-1:0] MRG_E_LO = MARGIN_WIDTH'((15 * SCALE) / 2);
  localparam logic [MARGIN_WIDTH-1:0] MRG_E_HI = MARGIN_WIDTH'(15 * SCALE);

  localparam logic [2:0] STATUS_NORMAL    = 3'd0;
  localparam logic [2:0] STATUS_OVERSPEED = 3'd1;
  localparam logic [2:0] STATUS_WARNING   = 3'd2;
  localparam logic [2:0] STATUS_SBI       = 3'd3;
  localparam logic [2:0] STATUS_EBI       = 3'd4;

  localparam logic [2:0] DISP_NORMAL       = 3'd0;
  localparam logic [2:0] DISP_OVERSPEED    = 3'd2;
  localparam logic [2:0] DISP_WARNING      = 3'd3;
  localparam logic [2:0] DISP_INTERVENTION = 3'd4;

  localparam logic [1:0] BRAKE_NONE      = 2'd0;
  localparam logic [1:0] BRAKE_SERVICE   = 2'd1;
  localparam logic [1:0] BRAKE_EMERGENCY = 2'd2;

  typedef enum logic [4:0] {
    ST_NORMAL    = 5'b00001,
    ST_OVERSPEED = 5'b00010,
    ST_WARNING   = 5'b00100,
    ST_SBI       = 5'b01000,
    ST_EBI       = 5'b10000
  } status_e;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] speed_estimate;
    logic [SPEED_WIDTH-1:0] speed_permitted;
  } in_t;

  typedef struct packed {
    logic [2:0] supervision_status;
    logic [2:0] display_command;
    logic       display_sbi_flag;
    logic [1:0] brake_command;
  } out_t;

  typedef struct packed {
    logic [MARGIN_WIDTH-1:0] wrn;
    logic [MARGIN_WIDTH-1:0] sbi;
    logic [MARGIN_WIDTH-1:0] ebi;
  } quot_t;

  typedef struct packed {
    logic above;
    logic over_wrn;
    logic over_sbi;
    logic over_ebi;
    logic standstill;
  } flags_t;

  function automatic out_t css_result(status_e st);
    out_t r;
    case (st)
      ST_NORMAL: begin
        r = '{STATUS_NORMAL, DISP_NORMAL, 1'b0, BRAKE_NONE};
      end
      ST_OVERSPEED: begin
        r = '{STATUS_OVERSPEED, DISP_OVERSPEED, 1'b1, BRAKE_NONE};
      end
      ST_WARNING: begin
        r = '{STATUS_WARNING, DISP_WARNING, 1'b1, BRAKE_NONE};
      end
      ST_SBI: begin
        r = '{STATUS_SBI, DISP_INTERVENTION, 1'b1, BRAKE_SERVICE};
      end
      default: begin
        r = '{STATUS_EBI, DISP_INTERVENTION, 1'b1, BRAKE_EMERGENCY};
      end
    endcase
    return r;
  endfunction

endpackage

### src/ceiling_speed_supervisor_top.sv
// Ceiling speed supervisor: four-register pipeline, one transfer per cycle unless the output stalls.
// One item per cycle unless the output stalls; stages advance independently, bubbles squeeze out.
// Stage order: input register, margin quotients, compare flags, status and result.
// Reset clears all stage valids and sets the status to normal.
// Depends on css_pkg, css_margin and ceiling_speed_supervisor_top_macros.svh.
`timescale 1ns / 1ps
`include "ceiling_speed_supervisor_top_macros.svh"

module ceiling_speed_supervisor_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  css_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output css_pkg::out_t  out_data_o
);

  localparam int unsigned CW = css_pkg::CALC_WIDTH;
  localparam int unsigned SW = css_pkg::SPEED_WIDTH;

  logic              s1_v_q;
  css_pkg::in_t      s1_q;
  logic              s2_v_q;
  css_pkg::in_t      s2_q;
  css_pkg::quot_t    s2_quot_q;
  css_pkg::quot_t    quot;
  logic              s3_v_q;
  css_pkg::flags_t   s3_flags_q;
  css_pkg::flags_t   flags_d;
  logic              out_v_q;
  css_pkg::out_t     out_q;
  css_pkg::status_e  status_q;
  css_pkg::status_e  status_d;
  css_pkg::status_e  status_nx;
  css_pkg::status_e  lvl;

  logic              out_rdy;
  logic              s3_rdy;
  logic              s2_rdy;
  logic              s1_rdy;

  logic [css_pkg::MARGIN_WIDTH-1:0] mrg_w;
  logic [css_pkg::MARGIN_WIDTH-1:0] mrg_s;
  logic [css_pkg::MARGIN_WIDTH-1:0] mrg_e;
  logic [CW-1:0]                    vp_c;
  logic [CW-1:0]                    est_c;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  // Stage 1: input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_q <= in_data_i;
    end
  end

  // Stage 2: margin quotients.
  css_margin u_margin (
    .speed_permitted_i (s1_q.speed_permitted),
    .quot_o            (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_rdy) begin
      s2_q      <= s1_q;
      s2_quot_q <= quot;
    end
  end

  // Stage 3: margin select and compare.
  assign vp_c  = CW'(s2_q.speed_permitted);
  assign est_c = CW'(s2_q.speed_estimate);

  always_comb begin
    if (vp_c <= css_pkg::V110) begin
      mrg_w = css_pkg::MRG_W_LO;
      mrg_s = css_pkg::MRG_S_LO;
      mrg_e = css_pkg::MRG_E_LO;
    end else begin
      mrg_w = (vp_c <= css_pkg::V140) ? s2_quot_q.wrn : css_pkg::MRG_W_HI;
      mrg_s = (vp_c <= css_pkg::V210) ? s2_quot_q.sbi : css_pkg::MRG_S_HI;
      mrg_e = (vp_c <= css_pkg::V210) ? s2_quot_q.ebi : css_pkg::MRG_E_HI;
    end
    flags_d.above      = est_c > vp_c;
    flags_d.over_wrn   = est_c > (vp_c + CW'(mrg_w));
    flags_d.over_sbi   = est_c > (vp_c + CW'(mrg_s));
    flags_d.over_ebi   = est_c > (vp_c + CW'(mrg_e));
    flags_d.standstill = s2_q.speed_estimate == SW'(0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_rdy) begin
      s3_flags_q <= flags_d;
    end
  end

  // Stage 4: status update and result register.
  always_comb begin
    lvl       = css_pkg::ST_OVERSPEED;
    status_nx = status_q;
    case (status_q)
      css_pkg::ST_NORMAL, css_pkg::ST_OVERSPEED, css_pkg::ST_WARNING,
      css_pkg::ST_SBI: begin
        if (!s3_flags_q.above) begin
          status_nx = css_pkg::ST_NORMAL;
        end else begin
          if (status_q != css_pkg::ST_NORMAL) begin
            lvl = status_q;
          end
          if (lvl == css_pkg::ST_OVERSPEED && s3_flags_q.over_wrn) begin
            lvl = css_pkg::ST_WARNING;
          end
          if (lvl == css_pkg::ST_WARNING && s3_flags_q.over_sbi) begin
            lvl = css_pkg::ST_SBI;
          end
          if (lvl == css_pkg::ST_SBI && s3_flags_q.over_ebi) begin
            lvl = css_pkg::ST_EBI;
          end
          status_nx = lvl;
        end
      end
      default: begin
        status_nx = s3_flags_q.standstill ? css_pkg::ST_NORMAL : css_pkg::ST_EBI;
      end
    endcase
    status_d = (s3_v_q && out_rdy) ? status_nx : status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= css_pkg::ST_NORMAL;
      out_v_q  <= 1'b0;
    end else begin
      status_q <= status_d;
      if (out_rdy) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && out_rdy) begin
      out_q <= css_pkg::css_result(status_d);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `CSS_ASSERT_NXT(a_ebi_hold,
    s3_v_q && out_rdy && status_q == css_pkg::ST_EBI && !s3_flags_q.standstill,
    status_q == css_pkg::ST_EBI, "emergency status left while moving")
  `CSS_ASSERT_NXT(a_drop_normal,
    s3_v_q && out_rdy && status_q != css_pkg::ST_EBI && !s3_flags_q.above,
    status_q == css_pkg::ST_NORMAL, "status did not return to normal")
  `CSS_ASSERT_NXT(a_out_track, s3_v_q && out_rdy,
    out_v_q && out_q == css_pkg::css_result(status_q), "result differs from status")
  `CSS_ASSERT_IMP(a_no_skip, s3_v_q && out_rdy && status_q == css_pkg::ST_NORMAL,
    status_nx != css_pkg::ST_EBI || s3_flags_q.over_ebi, "emergency entered below margin")

endmodule

### src/css_margin.sv
// Sloped margin segments: rounded constant divisions by reciprocal multiply.
// Depends on css_pkg.
`timescale 1ns / 1ps

module css_margin (
  input  logic [css_pkg::SPEED_WIDTH-1:0] speed_permitted_i,
  output css_pkg::quot_t                  quot_o
);

  localparam int unsigned CW  = css_pkg::CALC_WIDTH;
  localparam int unsigned MW  = css_pkg::MARGIN_WIDTH;
  localparam int unsigned NWW = css_pkg::NUM_W_WIDTH;
  localparam int unsigned NWS = css_pkg::NUM_S_WIDTH;
  localparam int unsigned NWE = css_pkg::NUM_E_WIDTH;
  localparam int unsigned LW  = $clog2(30);
  localparam int unsigned LS  = $clog2(200);
  localparam int unsigned LE  = $clog2(40);

  localparam longint unsigned RCP_W = ((64'd1 << (NWW + LW)) + 64'd29) / 64'd30;
  localparam longint unsigned RCP_S = ((64'd1 << (NWS + LS)) + 64'd199) / 64'd200;
  localparam longint unsigned RCP_E = ((64'd1 << (NWE + LE)) + 64'd39) / 64'd40;

  localparam logic [NWW:0] RCP_W_C = (NWW + 1)'(RCP_W);
  localparam logic [NWS:0] RCP_S_C = (NWS + 1)'(RCP_S);
  localparam logic [NWE:0] RCP_E_C = (NWE + 1)'(RCP_E);

  logic [CW-1:0]    vp_c;
  logic [CW-1:0]    v_w;
  logic [CW-1:0]    v_s;
  logic [NWW-1:0]   num_w;
  logic [NWS-1:0]   num_s;
  logic [NWE-1:0]   num_e;
  logic [2*NWW:0]   prod_w;
  logic [2*NWS:0]   prod_s;
  logic [2*NWE:0]   prod_e;

  assign vp_c = CW'(speed_permitted_i);

  // Clamp into the sloped segment so numerators stay in range.
  assign v_w = (vp_c > css_pkg::V140) ? css_pkg::V140 :
               ((vp_c < css_pkg::V110) ? css_pkg::V110 : vp_c);
  assign v_s = (vp_c > css_pkg::V210) ? css_pkg::V210 :
               ((vp_c < css_pkg::V110) ? css_pkg::V110 : vp_c);

  assign num_w = NWW'(v_w + CW'(10 * css_pkg::SCALE + 15));
  assign num_s = NWS'(CW'(9) * v_s + CW'(110 * css_pkg::SCALE + 100));
  assign num_e = NWE'(CW'(3) * v_s - CW'(30 * css_pkg::SCALE) + CW'(20));

  assign prod_w = (2 * NWW + 1)'(num_w) * (2 * NWW + 1)'(RCP_W_C);
  assign prod_s = (2 * NWS + 1)'(num_s) * (2 * NWS + 1)'(RCP_S_C);
  assign prod_e = (2 * NWE + 1)'(num_e) * (2 * NWE + 1)'(RCP_E_C);

  assign quot_o.wrn = MW'(prod_w[2*NWW:NWW+LW]);
  assign quot_o.sbi = MW'(prod_s[2*NWS:NWS+LS]);
  assign quot_o.ebi = MW'(prod_e[2*NWE:NWE+LE]);

endmodule

### bench/tb_ceiling_speed_supervisor_top.sv
// Testbench for ceiling_speed_supervisor_top: directed and random speed profiles,
// with results checked in order against a status predictor held in this file.
// Depends on css_pkg and the ceiling_speed_supervisor_top RTL.
`timescale 1ns / 1ps

module tb_ceiling_speed_supervisor_top;

  localparam int unsigned     SW        = css_pkg::SPEED_WIDTH;
  localparam longint unsigned SCALE     = css_pkg::SCALE;
  localparam longint unsigned SPEED_MAX = (64'd1 << SW) - 1;
  localparam int unsigned     IDLE_PCT  = 38;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  css_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  css_pkg::out_t out_data_o;

  logic          no_idle = 1'b0;
  logic [2:0]    model_status;
  css_pkg::out_t expected_results[$];
  css_pkg::out_t want;
  int            err_count = 0;
  longint unsigned bp_list[6];

  ceiling_speed_supervisor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Margins in 1/SCALE km/h, rounded to nearest.
  function automatic longint unsigned warn_margin(longint unsigned v);
    longint unsigned sc;
    sc = SCALE;
    if (v <= 110 * sc) return 4 * sc;
    if (v <= 140 * sc) return (v + 10 * sc + 15) / 30;
    return 5 * sc;
  endfunction

  function automatic longint unsigned sbi_margin(longint unsigned v);
    longint unsigned sc;
    sc = SCALE;
    if (v <= 110 * sc) return (11 * sc) / 2;
    if (v <= 210 * sc) return (9 * v + 110 * sc + 100) / 200;
    return 10 * sc;
  endfunction

  function automatic longint unsigned ebi_margin(longint unsigned v);
    longint unsigned sc;
    sc = SCALE;
    if (v <= 110 * sc) return (15 * sc) / 2;
    if (v <= 210 * sc) return (3 * v - 30 * sc + 20) / 40;
    return 15 * sc;
  endfunction

  task automatic advance_status(input css_pkg::in_t item, output css_pkg::out_t res);
    longint unsigned est;
    longint unsigned vp;
    logic [2:0]      s;
    est = item.speed_estimate;
    vp  = item.speed_permitted;
    s   = model_status;
    if (s >= css_pkg::STATUS_EBI) begin
      s = (est == 0) ? css_pkg::STATUS_NORMAL : css_pkg::STATUS_EBI;
    end else if (est <= vp) begin
      s = css_pkg::STATUS_NORMAL;
    end else begin
      if (s == css_pkg::STATUS_NORMAL) s = css_pkg::STATUS_OVERSPEED;
      if (s == css_pkg::STATUS_OVERSPEED && est > vp + warn_margin(vp))
        s = css_pkg::STATUS_WARNING;
      if (s == css_pkg::STATUS_WARNING && est > vp + sbi_margin(vp))
        s = css_pkg::STATUS_SBI;
      if (s == css_pkg::STATUS_SBI && est > vp + ebi_margin(vp))
        s = css_pkg::STATUS_EBI;
    end
    model_status = s;
    res.supervision_status = s;
    res.display_sbi_flag   = (s != css_pkg::STATUS_NORMAL);
    case (s)
      css_pkg::STATUS_NORMAL: begin
        res.display_command = css_pkg::DISP_NORMAL;
        res.brake_command   = css_pkg::BRAKE_NONE;
      end
      css_pkg::STATUS_OVERSPEED: begin
        res.display_command = css_pkg::DISP_OVERSPEED;
        res.brake_command   = css_pkg::BRAKE_NONE;
      end
      css_pkg::STATUS_WARNING: begin
        res.display_command = css_pkg::DISP_WARNING;
        res.brake_command   = css_pkg::BRAKE_NONE;
      end
      css_pkg::STATUS_SBI: begin
        res.display_command = css_pkg::DISP_INTERVENTION;
        res.brake_command   = css_pkg::BRAKE_SERVICE;
      end
      default: begin
        res.display_command = css_pkg::DISP_INTERVENTION;
        res.brake_command   = css_pkg::BRAKE_EMERGENCY;
      end
    endcase
  endtask

  task automatic send_speeds(input longint unsigned est, input longint unsigned vp);
    css_pkg::in_t  item;
    css_pkg::out_t res;
    item.speed_estimate  = SW'(est);
    item.speed_permitted = SW'(vp);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    advance_status(item, res);
    expected_results.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected transfer at %0t: status %0d disp %0d sbi %0d brake %0d",
                   $realtime, out_data_o.supervision_status, out_data_o.display_command,
                   out_data_o.display_sbi_flag, out_data_o.brake_command);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.supervision_status !== want.supervision_status ||
            out_data_o.display_command    !== want.display_command ||
            out_data_o.display_sbi_flag   !== want.display_sbi_flag ||
            out_data_o.brake_command      !== want.brake_command) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch at %0t: want st %0d disp %0d sbi %0d brk %0d, got %0d %0d %0d %0d",
                     $realtime, want.supervision_status, want.display_command,
                     want.display_sbi_flag, want.brake_command,
                     out_data_o.supervision_status, out_data_o.display_command,
                     out_data_o.display_sbi_flag, out_data_o.brake_command);
          end
        end
      end
    end
  end

  function automatic longint unsigned profile_estimate(longint unsigned v);
    longint unsigned e;
    case ($urandom_range(0, 9))
      0: e = 0;
      1, 2: e = (v > 3 * SCALE) ? v - $urandom_range(0, 3 * SCALE) : $urandom_range(0, v);
      3: e = v + $urandom_range(1, 2 * SCALE);
      4: e = v + warn_margin(v) + $urandom_range(0, 1);
      5: e = v + sbi_margin(v) + $urandom_range(0, 1);
      6: e = v + ebi_margin(v) + $urandom_range(0, 1);
      7: e = v + $urandom_range(0, 20 * SCALE);
      8: e = v;
      default: e = $urandom_range(0, SPEED_MAX);
    endcase
    if (e > SPEED_MAX) e = SPEED_MAX;
    return e;
  endfunction

  task automatic run_profiles(input int n_items);
    int              sent;
    int              len;
    int              r;
    longint unsigned v;
    longint unsigned bp;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        v = $urandom_range(0, 260 * SCALE);
      end else if (r < 9) begin
        case ($urandom_range(0, 2))
          0: bp = 110 * SCALE;
          1: bp = 140 * SCALE;
          default: bp = 210 * SCALE;
        endcase
        v = bp + $urandom_range(0, 2 * SCALE) - SCALE;
      end else begin
        v = $urandom_range(0, SPEED_MAX);
      end
      len = $urandom_range(4, 16);
      for (int i = 0; i < len; i++) begin
        send_speeds(profile_estimate(v), v);
        sent++;
      end
    end
  endtask

  task automatic test_extremes();
    send_speeds(0, 0);
    send_speeds(SPEED_MAX, SPEED_MAX);
    send_speeds(SPEED_MAX, 0);
    send_speeds(0, SPEED_MAX);
  endtask

  // Climb one level at a time; a speed just above permitted holds the level.
  task automatic test_held_status();
    longint unsigned v;
    v = 100 * SCALE;
    send_speeds(v + 1, v);
    send_speeds(v + warn_margin(v) + 1, v);
    send_speeds(v + 1, v);
    send_speeds(v + sbi_margin(v) + 1, v);
    send_speeds(v + 1, v);
    send_speeds(v, v);
  endtask

  // Emergency is left only at standstill.
  task automatic test_standstill_release();
    longint unsigned v;
    v = 100 * SCALE;
    send_speeds(v + ebi_margin(v) + 1, v);
    send_speeds(v, v);
    send_speeds(1, 0);
    send_speeds(0, v);
  endtask

  task automatic test_margin_breakpoints();
    longint unsigned v;
    foreach (bp_list[i]) begin
      v = bp_list[i];
      send_speeds(v + ebi_margin(v) + 1, v);
      send_speeds(0, v);
    end
  endtask

  task automatic test_random_profiles();
    run_profiles(1100);
  endtask

  task automatic test_back_to_back();
    no_idle <= 1'b1;
    run_profiles(200);
    no_idle <= 1'b0;
  endtask

  task automatic test_random_noise();
    longint unsigned est;
    for (int i = 0; i < 200; i++) begin
      est = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, SPEED_MAX);
      send_speeds(est, $urandom_range(0, SPEED_MAX));
    end
  endtask

  initial begin
    model_status = css_pkg::STATUS_NORMAL;
    bp_list[0] = 110 * SCALE;
    bp_list[1] = 110 * SCALE + 1;
    bp_list[2] = 140 * SCALE;
    bp_list[3] = 140 * SCALE + 1;
    bp_list[4] = 210 * SCALE;
    bp_list[5] = 210 * SCALE + 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_held_status();
    test_standstill_release();
    test_margin_breakpoints();
    wait_drained();
    test_random_profiles();
    wait_drained();
    test_back_to_back();
    wait_drained();
    test_random_noise();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
